@@ sv/esla_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// esla_pkg
// Types, register indexes and fixed-point helpers shared by the edge unit.
// ----------------------------------------------------------------------------
package esla_pkg;

    typedef struct packed {
        logic        kind;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
    } in_word_t;

    typedef struct packed {
        logic [15:0] edge_opacity;
        logic        write_enable;
        logic        frame_end;
    } out_word_t;

    // Neighbour mask for one window evaluation
    typedef struct packed {
        logic left;
        logic right;
        logic up;
        logic down;
    } edge_flags_t;

    typedef logic [31:0] cell_t;

    localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_L_ENABLE     = 3'd2;
    localparam logic [2:0] CFG_A_ENABLE     = 3'd3;
    localparam logic [2:0] CFG_L_GAIN       = 3'd4;
    localparam logic [2:0] CFG_A_GAIN       = 3'd5;

    localparam logic [15:0] FULL_SCALE = 16'hFFFF;
    localparam logic        KIND_FLUSH = 1'b1;

    // Floor of m / 65535 by folding the high half twice.
    function automatic logic [18:0] div65535(input logic [34:0] m);
        logic [18:0] q0;
        logic [19:0] r0;
        logic [3:0]  q1;
        logic [16:0] r1;
        q0 = m[34:16];
        r0 = {4'd0, m[15:0]} + {1'b0, q0};
        q1 = r0[19:16];
        r1 = {1'b0, r0[15:0]} + {13'd0, q1};
        div65535 = q0 + {15'd0, q1} + {18'd0, (r1 >= 17'd65535)};
    endfunction

endpackage
`default_nettype wire

@@ sv/edge_strength_3x3_lightness_alpha_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// edge_strength_3x3_lightness_alpha_unit
// 3x3 morphological edge strength over lightness and alpha of an RGBA stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order; each result word leaves one row plus one
// pixel after its pixel, so image_width+1 flush words (kind = 1) follow the
// last pixel of a frame. A flush word during the pixel phase is dropped with
// no result. Each word is taken while both line stores are read at its
// column, then goes through the lightness multiply, then is divided, written
// back and shifted into the window. A word that yields a result then has the
// window extremes found, gain and blend applied and the output register
// loaded, and waits while the output stays stalled. The line stores are two
// MAX_WIDTH x 32 synchronous RAMs holding {lightness, alpha}; their single
// read-modify-write per word sets the pace. No clearing pass is needed: rows
// never written are outside the image and masked off. Write the registers
// only while the unit is idle.
// ----------------------------------------------------------------------------
module edge_strength_3x3_lightness_alpha_unit #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_stall,
    input  esla_pkg::in_word_t    in_data,
    output logic                  out_valid,
    input  wire                   out_stall,
    output esla_pkg::out_word_t   out_data,
    input  wire                   cfg_we,
    input  wire  [2:0]            cfg_index,
    input  wire  [16:0]           cfg_data
);
    import esla_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_UPD  = 6'b000100,
        S_CALC = 6'b001000,
        S_WAIT = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [12:0] width_reg;
    logic [15:0] height_reg;
    logic        l_en_reg, a_en_reg;
    logic [16:0] l_gain_reg, a_gain_reg;

    // position and counters
    logic [AW-1:0] col_reg;
    logic [16:0]   row_reg;
    logic [31:0]   emitted_reg;
    logic [31:0]   area_reg;

    // item in flight
    in_word_t      item_reg;
    logic          pix_reg;
    logic [32:0]   lprod_reg;

    cell_t         win_reg [3][3];
    edge_flags_t   flags_reg;
    logic          end_reg;

    out_word_t     out_reg;
    logic          out_valid_reg;

    logic [31:0] up_rd, mid_rd;
    logic        accept, pix_phase;
    logic [31:0] w32;
    logic [WW-1:0] w_eff;
    logic [15:0] h_eff;
    logic [16:0] h17;

    logic [15:0] hi, lo;
    logic [16:0] s_sum;
    logic [18:0] l_q;
    logic [15:0] l_val;
    cell_t       cell_c;
    logic        emit_a, emit_b, emit, ends, clear;
    logic [WW-1:0] x_ext;
    logic [31:0] cnt_inc;
    edge_flags_t flags_c;

    logic        calc_done;
    logic [15:0] calc_value;
    logic        out_free;

    // ---- effective sizes
    always_comb
    begin
        if (width_reg == 13'd0)
        begin
            w32 = 32'd1;
        end
        else if ({19'd0, width_reg} > 32'(MAX_WIDTH))
        begin
            w32 = 32'(MAX_WIDTH);
        end
        else
        begin
            w32 = {19'd0, width_reg};
        end
        w_eff = w32[WW-1:0];
        h_eff = (height_reg == 16'd0) ? 16'd1 : height_reg;
        h17   = {1'b0, h_eff};
    end

    assign pix_phase = row_reg < h17;
    assign accept    = (state_reg == S_IDLE) && in_valid;
    assign in_stall  = (state_reg != S_IDLE);

    // ---- lightness: (max+min)*alpha / 131070, rounded half up
    always_comb
    begin
        hi = item_reg.red;
        lo = item_reg.red;
        if (item_reg.green > hi) hi = item_reg.green;
        if (item_reg.blue  > hi) hi = item_reg.blue;
        if (item_reg.green < lo) lo = item_reg.green;
        if (item_reg.blue  < lo) lo = item_reg.blue;
        s_sum = {1'b0, hi} + {1'b0, lo};
        l_q   = div65535({2'd0, lprod_reg} + 35'd65535 >> 1);
        l_val = (l_q > 19'd65535) ? FULL_SCALE : l_q[15:0];
        cell_c = pix_reg ? {l_val, item_reg.alpha} : '0;
    end

    // ---- position bookkeeping for the update cycle
    always_comb
    begin
        x_ext   = WW'(col_reg);
        emit_a  = (col_reg == '0) && (row_reg >= 17'd2) && (row_reg <= h17 + 17'd1);
        emit_b  = (col_reg != '0) && (row_reg >= 17'd1) && (row_reg <= h17);
        emit    = emit_a || emit_b;
        cnt_inc = emitted_reg + 32'd1;
        ends    = emit && (cnt_inc >= area_reg);
        clear   = ends || (row_reg >= h17 + 17'd1);
        if (emit_a)
        begin
            // centre is the last column of the row two above
            flags_c.left  = (w_eff > WW'(1));
            flags_c.right = 1'b0;
            flags_c.up    = (row_reg > 17'd2);
            flags_c.down  = (row_reg - 17'd1) < h17;
        end
        else
        begin
            flags_c.left  = (x_ext > WW'(1));
            flags_c.right = (x_ext < w_eff);
            flags_c.up    = (row_reg > 17'd1);
            flags_c.down  = (row_reg < h17);
        end
    end

    // ---- line stores: upper takes old middle, middle takes the new cell
    esla_line_ram #(.DEPTH(MAX_WIDTH)) u_upper (
        .clk     (clk),
        .wr_en   (state_reg == S_UPD),
        .wr_addr (col_reg),
        .wr_data (mid_rd),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (up_rd)
    );

    esla_line_ram #(.DEPTH(MAX_WIDTH)) u_middle (
        .clk     (clk),
        .wr_en   (state_reg == S_UPD),
        .wr_addr (col_reg),
        .wr_data (cell_c),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (mid_rd)
    );

    esla_edge_calc u_calc (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_CALC),
        .win      (win_reg),
        .flags    (flags_reg),
        .l_enable (l_en_reg),
        .a_enable (a_en_reg),
        .l_gain   (l_gain_reg),
        .a_gain   (a_gain_reg),
        .done     (calc_done),
        .value    (calc_value)
    );

    assign out_free = !out_valid_reg || !out_stall;

    // ---- sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                // drop a flush word that arrives during the pixel phase
                if (accept && !(pix_phase && in_data.kind == KIND_FLUSH))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:  state_next = S_UPD;
            S_UPD:  state_next = emit ? S_CALC : S_IDLE;
            S_CALC: state_next = S_WAIT;
            S_WAIT:
            begin
                if (calc_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= 13'd1;
            height_reg    <= 16'd1;
            l_en_reg      <= 1'b0;
            a_en_reg      <= 1'b0;
            l_gain_reg    <= '0;
            a_gain_reg    <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            emitted_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[12:0];
                    CFG_IMAGE_HEIGHT: height_reg <= cfg_data[15:0];
                    CFG_L_ENABLE:     l_en_reg   <= cfg_data[0];
                    CFG_A_ENABLE:     a_en_reg   <= cfg_data[0];
                    CFG_L_GAIN:       l_gain_reg <= cfg_data;
                    CFG_A_GAIN:       a_gain_reg <= cfg_data;
                    default:          ;
                endcase
            end

            if (state_reg == S_UPD)
            begin
                // advance the window one column
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= up_rd;
                win_reg[1][2] <= mid_rd;
                win_reg[2][2] <= cell_c;

                if (clear)
                begin
                    col_reg     <= '0;
                    row_reg     <= '0;
                    emitted_reg <= '0;
                end
                else
                begin
                    if (x_ext + WW'(1) >= w_eff)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + 17'd1;
                    end
                    else
                    begin
                        col_reg <= col_reg + AW'(1);
                    end
                    if (emit)
                    begin
                        emitted_reg <= cnt_inc;
                    end
                end
            end

            // load a new result word, or drop the one just taken
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---- payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
            pix_reg  <= pix_phase;
            area_reg <= 32'(w_eff) * 32'(h_eff);
        end
        if (state_reg == S_MUL)
        begin
            lprod_reg <= s_sum * item_reg.alpha;
        end
        if (state_reg == S_UPD)
        begin
            flags_reg <= flags_c;
            end_reg   <= ends;
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_reg.write_enable <= l_en_reg || a_en_reg;
            out_reg.edge_opacity <= (l_en_reg || a_en_reg) ? calc_value : 16'd0;
            out_reg.frame_end    <= end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule
`default_nettype wire

@@ sv/esla_line_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// esla_line_ram
// One-row line store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module esla_line_ram #(
    parameter int DEPTH = 4096
) (
    input  wire                        clk,
    input  wire                        wr_en,
    input  wire  [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire  [31:0]                wr_data,
    input  wire                        rd_en,
    input  wire  [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [31:0]                rd_data
);
    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

@@ sv/esla_edge_calc.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// esla_edge_calc
// Evaluation of one 3x3 window: extremes, gain, saturate, then blend and divide, or one term.
// ----------------------------------------------------------------------------
module esla_edge_calc (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       start,
    input  esla_pkg::cell_t           win [3][3],
    input  esla_pkg::edge_flags_t     flags,
    input  wire                       l_enable,
    input  wire                       a_enable,
    input  wire  [16:0]               l_gain,
    input  wire  [16:0]               a_gain,
    output logic                      done,
    output logic [15:0]               value
);
    import esla_pkg::*;

    logic [3:0]  stage_reg;
    logic [15:0] rise_reg, drop_reg;
    logic [32:0] p0_raw_reg, p1_raw_reg;
    logic [15:0] p0_reg, p1_reg;
    logic [31:0] prod_reg;
    logic [16:0] sum_reg;
    logic [15:0] value_reg;

    logic [15:0] rise_c, drop_c, lc, ac, ln, an;
    logic        use_n;
    logic [33:0] p0_r, p1_r;
    logic [17:0] p0_s, p1_s;
    logic [34:0] num;
    logic [18:0] q;
    logic [15:0] val_c;

    always_comb
    begin
        lc = win[1][1][31:16];
        ac = win[1][1][15:0];
        rise_c = '0;
        drop_c = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                ln = win[r][c][31:16];
                an = win[r][c][15:0];
                use_n = !(r == 1 && c == 1)
                        && (r != 0 || flags.up) && (r != 2 || flags.down)
                        && (c != 0 || flags.left) && (c != 2 || flags.right);
                if (use_n && ln > lc && (ln - lc) > rise_c)
                begin
                    rise_c = ln - lc;
                end
                if (use_n && ac > an && (ac - an) > drop_c)
                begin
                    drop_c = ac - an;
                end
            end
        end
    end

    always_comb
    begin
        p0_r = {1'b0, p0_raw_reg} + 34'd32768;
        p1_r = {1'b0, p1_raw_reg} + 34'd32768;
        p0_s = p0_r[33:16];
        p1_s = p1_r[33:16];
        num  = ({18'd0, sum_reg} << 16) - {18'd0, sum_reg} - {3'd0, prod_reg} + 35'd32767;
        q    = div65535(num);
        if (l_enable && a_enable)
        begin
            val_c = (q > 19'd65535) ? FULL_SCALE : q[15:0];
        end
        else if (l_enable)
        begin
            val_c = p0_reg;
        end
        else
        begin
            val_c = p1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= {stage_reg[2:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rise_reg <= rise_c;
            drop_reg <= drop_c;
        end
        if (stage_reg[0])
        begin
            p0_raw_reg <= rise_reg * l_gain;
            p1_raw_reg <= drop_reg * a_gain;
        end
        if (stage_reg[1])
        begin
            p0_reg   <= (p0_s > 18'd65535) ? FULL_SCALE : p0_s[15:0];
            p1_reg   <= (p1_s > 18'd65535) ? FULL_SCALE : p1_s[15:0];
        end
        if (stage_reg[2])
        begin
            prod_reg <= p0_reg * p1_reg;
            sum_reg  <= {1'b0, p0_reg} + {1'b0, p1_reg};
        end
        if (stage_reg[3])
        begin
            value_reg <= val_c;
        end
    end

    // p0/p1 hold through stage 3 so the single-term select sees them;
    // the value is valid from the cycle after done and holds until the next done
    assign done  = stage_reg[3];
    assign value = value_reg;
endmodule
`default_nettype wire
